[rtl/gic_pkg.sv]
// Package for the gamepad input conditioner: fixed-point constants,
// configuration codes and the item and config structs shared by the top, front and back modules.
// No dependencies.
package gic_pkg;

  localparam int FRAC_BITS = 15;
  localparam logic [14:0] ONE = 15'((1 << FRAC_BITS) - 1);
  localparam logic [5:0] DEBUG_MASK = 6'b000100;

  localparam logic [1:0] CFG_PRESS_STEP       = 2'd0;
  localparam logic [1:0] CFG_RELEASE_STEP     = 2'd1;
  localparam logic [1:0] CFG_STICK_DEADZONE   = 2'd2;
  localparam logic [1:0] CFG_TRIGGER_DEADZONE = 2'd3;

  localparam logic [14:0] RST_PRESS_STEP       = 15'd2731;
  localparam logic [14:0] RST_RELEASE_STEP     = 15'd5461;
  localparam logic [14:0] RST_STICK_DEADZONE   = 15'd3277;
  localparam logic [14:0] RST_TRIGGER_DEADZONE = 15'd1638;

  typedef struct packed {
    logic        is_clear;
    logic [4:0]  held_keys;
    logic [5:0]  key_presses;
    logic        pad_present;
    logic signed [15:0] stick_x;
    logic signed [15:0] stick_y;
    logic signed [15:0] trigger_right;
    logic signed [15:0] trigger_left;
    logic        pad_handbrake;
    logic [5:0]  pad_presses;
  } item_t;

  typedef struct packed {
    logic [14:0] press_step;
    logic [14:0] release_step;
    logic [14:0] stick_deadzone;
    logic [14:0] trigger_deadzone;
  } cfg_t;

endpackage

[rtl/gamepad_input_conditioner.sv]
// Top level of the gamepad input conditioner: configuration registers and
// the front queue and back sequencer. Depends on gic_pkg, gic_front, gic_back.
//
// Usage:
//   Input channel (in_valid/in_stall) takes one item per frame: kind 0 is a
//   frame sample, kind 1 clears the latched one-shot events. Each item gives
//   exactly one result on the output channel (out_valid/out_stall).
//   Configuration writes (cfg_valid/cfg_ready, cfg_index, cfg_data) set the
//   pedal steps and the deadzones; cfg_ready is always high. Write them only
//   while no item is in flight.
// Sequencing:
//   A pad frame passes through the 16-step square root and the 16-step
//   divider that the back end runs one bit per cycle; the divider is skipped
//   when the stick lies inside the deadzone or when the rescale saturates.
//   Clear items and frames without a pad skip both. The back end holds one
//   item until its result enters the output register; a two-entry queue in
//   front takes new items while the back end works.
// Reset:
//   rst (synchronous) empties the queue, drops any pending result, zeroes
//   the pedal travels and event latch and restores register defaults.
// Stall:
//   A stalled result holds in the output register; the back end waits in
//   its final step, and the input stalls once the queue is full.
module gamepad_input_conditioner (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               kind,
  input  logic [4:0]         held_keys,
  input  logic [5:0]         key_presses,
  input  logic               pad_present,
  input  logic signed [15:0] stick_x,
  input  logic signed [15:0] stick_y,
  input  logic signed [15:0] trigger_right,
  input  logic signed [15:0] trigger_left,
  input  logic               pad_handbrake,
  input  logic [5:0]         pad_presses,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] steer,
  output logic [14:0]        throttle,
  output logic [14:0]        brake,
  output logic [14:0]        handbrake,
  output logic [5:0]         latched_events,
  output logic               any_event,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [14:0]        cfg_data
);

  gic_pkg::cfg_t  cfg;
  gic_pkg::item_t q_item;
  logic           q_valid;
  logic           q_pop;

  assign cfg_ready = 1'b1;

  // hold register values; update the addressed one on a write
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.press_step       <= gic_pkg::RST_PRESS_STEP;
      cfg.release_step     <= gic_pkg::RST_RELEASE_STEP;
      cfg.stick_deadzone   <= gic_pkg::RST_STICK_DEADZONE;
      cfg.trigger_deadzone <= gic_pkg::RST_TRIGGER_DEADZONE;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        gic_pkg::CFG_PRESS_STEP:       cfg.press_step       <= cfg_data;
        gic_pkg::CFG_RELEASE_STEP:     cfg.release_step     <= cfg_data;
        gic_pkg::CFG_STICK_DEADZONE:   cfg.stick_deadzone   <= cfg_data;
        gic_pkg::CFG_TRIGGER_DEADZONE: cfg.trigger_deadzone <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // accept and classify items into the queue
  gic_front u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .kind          (kind),
    .held_keys     (held_keys),
    .key_presses   (key_presses),
    .pad_present   (pad_present),
    .stick_x       (stick_x),
    .stick_y       (stick_y),
    .trigger_right (trigger_right),
    .trigger_left  (trigger_left),
    .pad_handbrake (pad_handbrake),
    .pad_presses   (pad_presses),
    .q_valid       (q_valid),
    .q_item        (q_item),
    .q_pop         (q_pop)
  );

  // advance one item at a time through the arithmetic
  gic_back u_back (
    .clk            (clk),
    .rst            (rst),
    .cfg            (cfg),
    .q_valid        (q_valid),
    .q_item         (q_item),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .steer          (steer),
    .throttle       (throttle),
    .brake          (brake),
    .handbrake      (handbrake),
    .latched_events (latched_events),
    .any_event      (any_event)
  );

endmodule

[rtl/gic_front.sv]
// Front end of the gamepad input conditioner: accepts and classifies items
// into a two-entry queue for the back end. Depends on gic_pkg.
module gic_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                kind,
  input  logic [4:0]          held_keys,
  input  logic [5:0]          key_presses,
  input  logic                pad_present,
  input  logic signed [15:0]  stick_x,
  input  logic signed [15:0]  stick_y,
  input  logic signed [15:0]  trigger_right,
  input  logic signed [15:0]  trigger_left,
  input  logic                pad_handbrake,
  input  logic [5:0]          pad_presses,
  output logic                q_valid,
  output gic_pkg::item_t      q_item,
  input  logic                q_pop
);

  gic_pkg::item_t slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  logic       pop;
  gic_pkg::item_t incoming;

  assign in_stall = (count == 2'd2);
  assign push     = in_valid && !in_stall;
  assign pop      = q_pop && q_valid;
  assign q_valid  = (count != 2'd0);
  assign q_item   = slots[rd_ptr];

  always_comb begin
    incoming.is_clear      = kind;
    incoming.held_keys     = held_keys;
    incoming.key_presses   = key_presses;
    incoming.pad_present   = pad_present;
    incoming.stick_x       = stick_x;
    incoming.stick_y       = stick_y;
    incoming.trigger_right = trigger_right;
    incoming.trigger_left  = trigger_left;
    incoming.pad_handbrake = pad_handbrake;
    incoming.pad_presses   = pad_presses;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= incoming;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

[rtl/gic_back.sv]
// Back end of the gamepad input conditioner: sequencer with an iterative
// square root and divider, pedal ramps, event latch and output register.
// Depends on gic_pkg.
module gic_back (
  input  logic               clk,
  input  logic               rst,
  input  gic_pkg::cfg_t      cfg,
  input  logic               q_valid,
  input  gic_pkg::item_t     q_item,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] steer,
  output logic [14:0]        throttle,
  output logic [14:0]        brake,
  output logic [14:0]        handbrake,
  output logic [5:0]         latched_events,
  output logic               any_event
);

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_SQX  = 9'b000000010,
    S_SQY  = 9'b000000100,
    S_ROOT = 9'b000001000,
    S_MUL  = 9'b000010000,
    S_DEN  = 9'b000100000,
    S_CHK  = 9'b001000000,
    S_DIV  = 9'b010000000,
    S_DONE = 9'b100000000
  } state_t;

  state_t state;
  state_t state_next;

  gic_pkg::item_t it;
  logic [15:0] ax;
  logic [15:0] ay;
  logic [31:0] sqx;
  logic [31:0] rad;
  logic [16:0] root_rem;
  logic [15:0] mag;
  logic [3:0]  cnt;
  logic [31:0] prod;
  logic [46:0] num;
  logic [30:0] den;
  logic [30:0] drem;
  logic [15:0] nlo;
  logic [15:0] q;
  logic        sat;

  logic [14:0] throttle_travel;
  logic [14:0] brake_travel;
  logic [5:0]  event_latch;

  logic [14:0] dz;
  logic [14:0] one_m_dz;
  logic [18:0] rem_sh;
  logic [18:0] trial;
  logic [31:0] div_sh;
  logic        out_free;

  logic [14:0] thr_travel_next;
  logic [14:0] brk_travel_next;
  logic [5:0]  latch_next;
  logic [14:0] q_mag;
  logic signed [15:0] key_steer;
  logic signed [15:0] pad_steer;
  logic [14:0] akb;
  logic [14:0] agp;
  logic [14:0] gp_thr;
  logic [14:0] gp_brk;
  logic [14:0] thr_val;
  logic [14:0] brk_val;
  logic        hb;

  function automatic logic [15:0] abs16(input logic signed [15:0] v);
    abs16 = v[15] ? 16'(-v) : 16'(v);
  endfunction

  function automatic logic [14:0] ramp(input logic [14:0] cur, input logic held,
                                       input logic [14:0] ps, input logic [14:0] rs);
    logic [14:0] d;
    d = gic_pkg::ONE - cur;
    if (held) begin
      ramp = (d > ps) ? cur + ps : gic_pkg::ONE;
    end else begin
      ramp = (cur > rs) ? cur - rs : 15'd0;
    end
  endfunction

  function automatic logic [14:0] trig_norm(input logic signed [15:0] raw,
                                            input logic [14:0] tdz);
    logic signed [16:0] s;
    s = 17'(raw) + $signed({2'b00, gic_pkg::ONE});
    if (s < $signed({2'b00, tdz})) begin
      trig_norm = 15'd0;
    end else begin
      trig_norm = s[15:1];
    end
  endfunction

  assign dz       = (cfg.stick_deadzone > gic_pkg::ONE - 15'd1) ?
                    gic_pkg::ONE - 15'd1 : cfg.stick_deadzone;
  assign one_m_dz = gic_pkg::ONE - dz;
  assign rem_sh   = {root_rem, rad[31:30]};
  assign trial    = {1'b0, mag, 2'b01};
  assign div_sh   = {drem, nlo[15]};
  assign out_free = !out_valid || !out_stall;
  assign q_pop    = (state == S_IDLE) && q_valid;

  // result assembly for the item in the DONE state
  always_comb begin
    thr_travel_next = ramp(throttle_travel, it.held_keys[2],
                           cfg.press_step, cfg.release_step);
    brk_travel_next = ramp(brake_travel, it.held_keys[3],
                           cfg.press_step, cfg.release_step);
    latch_next = event_latch | it.key_presses |
                 (it.pad_present ? (it.pad_presses & ~gic_pkg::DEBUG_MASK) : 6'd0);
    q_mag = (sat || (q > {1'b0, gic_pkg::ONE})) ? gic_pkg::ONE : q[14:0];
    if (it.held_keys[0] && !it.held_keys[1]) begin
      key_steer = $signed({1'b0, gic_pkg::ONE});
    end else if (it.held_keys[1] && !it.held_keys[0]) begin
      key_steer = -$signed({1'b0, gic_pkg::ONE});
    end else begin
      key_steer = 16'sd0;
    end
    akb = (it.held_keys[0] ^ it.held_keys[1]) ? gic_pkg::ONE : 15'd0;
    agp = it.pad_present ? q_mag : 15'd0;
    if (!it.pad_present) begin
      pad_steer = 16'sd0;
    end else if (it.stick_x[15]) begin
      pad_steer = $signed({1'b0, q_mag});
    end else begin
      pad_steer = -$signed({1'b0, q_mag});
    end
    gp_thr = it.pad_present ? trig_norm(it.trigger_right, cfg.trigger_deadzone) : 15'd0;
    gp_brk = it.pad_present ? trig_norm(it.trigger_left, cfg.trigger_deadzone) : 15'd0;
    thr_val = (thr_travel_next > gp_thr) ? thr_travel_next : gp_thr;
    brk_val = (brk_travel_next > gp_brk) ? brk_travel_next : gp_brk;
    hb = it.held_keys[4] || (it.pad_present && it.pad_handbrake);
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (q_valid) begin
          state_next = (q_item.is_clear || !q_item.pad_present) ? S_DONE : S_SQX;
        end
      end
      S_SQX:  state_next = S_SQY;
      S_SQY:  state_next = S_ROOT;
      S_ROOT: state_next = (cnt == 4'd15) ? S_MUL : S_ROOT;
      S_MUL:  state_next = (mag <= {1'b0, dz}) ? S_DONE : S_DEN;
      S_DEN:  state_next = S_CHK;
      S_CHK:  state_next = (num[46:16] >= den) ? S_DONE : S_DIV;
      S_DIV:  state_next = (cnt == 4'd15) ? S_DONE : S_DIV;
      S_DONE: state_next = out_free ? S_IDLE : S_DONE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // datapath of the radial deadzone
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        it  <= q_item;
        ax  <= abs16(q_item.stick_x);
        ay  <= abs16(q_item.stick_y);
        q   <= 16'd0;
        sat <= 1'b0;
      end
      S_SQX: begin
        sqx <= ax * ax;
      end
      S_SQY: begin
        rad      <= sqx + ay * ay;
        root_rem <= 17'd0;
        mag      <= 16'd0;
        cnt      <= 4'd0;
      end
      S_ROOT: begin
        if (rem_sh >= trial) begin
          root_rem <= 17'(rem_sh - trial);
          mag      <= {mag[14:0], 1'b1};
        end else begin
          root_rem <= rem_sh[16:0];
          mag      <= {mag[14:0], 1'b0};
        end
        rad <= {rad[29:0], 2'b00};
        cnt <= cnt + 4'd1;
      end
      S_MUL: begin
        prod <= ax * (mag - {1'b0, dz});
      end
      S_DEN: begin
        den <= 31'(mag * one_m_dz);
        num <= {prod, 15'd0} - {15'd0, prod};
      end
      S_CHK: begin
        sat  <= (num[46:16] >= den);
        drem <= num[46:16];
        nlo  <= num[15:0];
        cnt  <= 4'd0;
      end
      S_DIV: begin
        if (div_sh >= {1'b0, den}) begin
          drem <= 31'(div_sh - {1'b0, den});
          q    <= {q[14:0], 1'b1};
        end else begin
          drem <= div_sh[30:0];
          q    <= {q[14:0], 1'b0};
        end
        nlo <= {nlo[14:0], 1'b0};
        cnt <= cnt + 4'd1;
      end
      S_DONE: begin
      end
      default: begin
      end
    endcase
  end

  // item state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      throttle_travel <= 15'd0;
      brake_travel    <= 15'd0;
      event_latch     <= 6'd0;
      out_valid       <= 1'b0;
    end else begin
      if ((state == S_DONE) && out_free) begin
        out_valid <= 1'b1;
        if (it.is_clear) begin
          event_latch <= 6'd0;
        end else begin
          throttle_travel <= thr_travel_next;
          brake_travel    <= brk_travel_next;
          event_latch     <= latch_next;
        end
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_DONE) && out_free) begin
      if (it.is_clear) begin
        steer          <= 16'sd0;
        throttle       <= 15'd0;
        brake          <= 15'd0;
        handbrake      <= 15'd0;
        latched_events <= 6'd0;
        any_event      <= 1'b0;
      end else begin
        steer          <= (akb >= agp) ? key_steer : pad_steer;
        throttle       <= thr_val;
        brake          <= brk_val;
        handbrake      <= hb ? gic_pkg::ONE : 15'd0;
        latched_events <= latch_next;
        any_event      <= (latch_next != 6'd0);
      end
    end
  end

endmodule

[rtl/gic_checker.sv]
// Port-level checker for the gamepad input conditioner, bound to the top.
// Depends on gamepad_input_conditioner.
module gic_checker (
  input logic               clk,
  input logic               rst,
  input logic               out_valid,
  input logic               out_stall,
  input logic signed [15:0] steer,
  input logic [14:0]        throttle,
  input logic [14:0]        handbrake,
  input logic [5:0]         latched_events,
  input logic               any_event
);

  a_reset_idle: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result shown right after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(steer) && $stable(throttle))
    else $error("stalled result changed");

  a_any_event: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (any_event == (latched_events != 6'd0)))
    else $error("any_event disagrees with latched events");

  a_handbrake: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (handbrake == 15'd0 || handbrake == 15'd32767))
    else $error("handbrake not full or zero");

endmodule

bind gamepad_input_conditioner gic_checker u_gic_checker (
  .clk            (clk),
  .rst            (rst),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .steer          (steer),
  .throttle       (throttle),
  .handbrake      (handbrake),
  .latched_events (latched_events),
  .any_event      (any_event)
);
